/* rtl/core/im2col_pkg.sv */
// Shared types, limits and register codes for the im2col address generator.
// No dependencies; every other file in rtl/core imports this package.
package im2col_pkg;

	localparam int MAX_DIM           = 1024;
	localparam int MAX_CHANNELS      = 1024;
	localparam int MAX_KERNEL        = 15;
	localparam int MAX_STRIDE        = 8;
	localparam int PIXELS_PER_BUFFER = 2;

	localparam int CFG_W   = 11;
	localparam int INDEX_W = 3;

	localparam logic [INDEX_W-1:0] REG_IN_DIM      = 3'd0;
	localparam logic [INDEX_W-1:0] REG_CHANNELS    = 3'd1;
	localparam logic [INDEX_W-1:0] REG_KERNEL_DIM  = 3'd2;
	localparam logic [INDEX_W-1:0] REG_PAD_SIZE    = 3'd3;
	localparam logic [INDEX_W-1:0] REG_STRIDE_STEP = 3'd4;
	localparam logic [INDEX_W-1:0] REG_OUT_DIM     = 3'd5;
	localparam logic [INDEX_W-1:0] REG_ROW_START   = 3'd6;
	localparam logic [INDEX_W-1:0] REG_ROW_STOP    = 3'd7;

	typedef struct packed {
		logic [10:0] idim;
		logic [10:0] odim;
		logic [10:0] ch;
		logic [3:0]  k;
		logic [3:0]  st;
		logic [2:0]  pad;
		logic [9:0]  row_start;
		logic [10:0] stop;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic adv1;
		logic adv2;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic go;
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_S1,
		ST_S2,
		ST_S3
	} state_t;

endpackage

/* rtl/core/im2col_cfg.sv */
// Configuration registers with range saturation for the im2col generator.
// Depends on im2col_pkg for register codes and the cfg_t struct.
module im2col_cfg import im2col_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output cfg_t               cfg
);

	logic [10:0] in_dim_q, channels_q, out_dim_q, row_stop_q;
	logic [3:0]  kernel_dim_q, stride_step_q;
	logic [2:0]  pad_size_q;
	logic [9:0]  row_start_q;
	logic [10:0] odim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_dim_q      <= 11'd32;
			channels_q    <= 11'd8;
			kernel_dim_q  <= 4'd3;
			pad_size_q    <= 3'd1;
			stride_step_q <= 4'd1;
			out_dim_q     <= 11'd32;
			row_start_q   <= 10'd0;
			row_stop_q    <= 11'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_DIM:      in_dim_q      <= cfg_data;
				REG_CHANNELS:    channels_q    <= cfg_data;
				REG_KERNEL_DIM:  kernel_dim_q  <= cfg_data[3:0];
				REG_PAD_SIZE:    pad_size_q    <= cfg_data[2:0];
				REG_STRIDE_STEP: stride_step_q <= cfg_data[3:0];
				REG_OUT_DIM:     out_dim_q     <= cfg_data;
				REG_ROW_START:   row_start_q   <= cfg_data[9:0];
				REG_ROW_STOP:    row_stop_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.idim = (in_dim_q == 11'd0) ? 11'd1 :
			(in_dim_q > 11'(MAX_DIM)) ? 11'(MAX_DIM) : in_dim_q;
		odim = (out_dim_q == 11'd0) ? 11'd1 :
			(out_dim_q > 11'(MAX_DIM)) ? 11'(MAX_DIM) : out_dim_q;
		cfg.odim = odim;
		cfg.ch = (channels_q == 11'd0) ? 11'd1 :
			(channels_q > 11'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : channels_q;
		cfg.k = (kernel_dim_q == 4'd0) ? 4'd1 :
			(kernel_dim_q > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kernel_dim_q;
		cfg.st = (stride_step_q == 4'd0) ? 4'd1 :
			(stride_step_q > 4'(MAX_STRIDE)) ? 4'(MAX_STRIDE) : stride_step_q;
		cfg.pad       = pad_size_q;
		cfg.row_start = row_start_q;
		cfg.stop      = (row_stop_q < odim) ? row_stop_q : odim;
	end

endmodule

/* rtl/core/im2col_ctrl.sv */
// Sequencing state machine for the im2col generator: input beat, three
// arithmetic stages, result register handover. Depends on im2col_pkg.
module im2col_ctrl import im2col_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && stat.go) begin
					state_d = ST_S1;
				end
			end
			ST_S1: begin
				cmd.adv1 = 1'b1;
				state_d  = ST_S2;
			end
			ST_S2: begin
				cmd.adv2 = 1'b1;
				state_d  = ST_S3;
			end
			ST_S3: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/im2col_dp.sv */
// Datapath of the im2col generator: scan counters, tap and offset arithmetic
// over three stages, result register. Depends on im2col_pkg.
module im2col_dp import im2col_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	input  logic        restart,
	output stat_t       stat,
	output logic [29:0] input_offset,
	output logic        zero_fill,
	output logic [18:0] buffer_index,
	output logic        patch_last,
	output logic        buffer_full,
	output logic        scan_done
);

	logic [9:0]  out_row_q, out_col_q, chan_q;
	logic [3:0]  tap_row_q, tap_col_q;
	logic [19:0] buf_pos_q;
	logic        finished_q;

	logic        nonempty;
	logic [14:0] ysum, xsum, ydiff, xdiff;
	logic        zf_y, zf_x;
	logic        chan_end, col_end, row_end, plast, pix_end, rows_end;

	logic        zf_s1, plast_s1, sdone_s1;
	logic [9:0]  yv_s1, xv_s1;
	logic [14:0] chk_s1;
	logic [19:0] pix_s2;
	logic [19:0] bufsize_s2;

	logic [30:0] offset;
	logic        bfull;

	assign nonempty = {1'b0, cfg.row_start} < cfg.stop;
	assign stat.go  = restart ? nonempty : !finished_q;

	always_comb begin
		ysum  = 15'(out_row_q * cfg.st) + 15'(tap_row_q);
		xsum  = 15'(out_col_q * cfg.st) + 15'(tap_col_q);
		ydiff = ysum - 15'(cfg.pad);
		xdiff = xsum - 15'(cfg.pad);
		zf_y  = (ysum < 15'(cfg.pad)) || (ydiff >= 15'(cfg.idim));
		zf_x  = (xsum < 15'(cfg.pad)) || (xdiff >= 15'(cfg.idim));
		chan_end = (11'(chan_q) + 11'd1) >= cfg.ch;
		col_end  = (5'(tap_col_q) + 5'd1) >= 5'(cfg.k);
		row_end  = (5'(tap_row_q) + 5'd1) >= 5'(cfg.k);
		plast    = chan_end && col_end && row_end;
		pix_end  = (11'(out_col_q) + 11'd1) >= cfg.odim;
		rows_end = (11'(out_row_q) + 11'd1) >= cfg.stop;
	end

	// stage 1: tap position and patch marks
	always_ff @(posedge clk) begin
		if (cmd.adv1) begin
			zf_s1    <= zf_y || zf_x;
			yv_s1    <= ydiff[9:0];
			xv_s1    <= xdiff[9:0];
			plast_s1 <= plast;
			sdone_s1 <= plast && pix_end && rows_end;
			chk_s1   <= 15'(cfg.ch * cfg.k);
		end
	end

	// stage 2: pixel index and buffer size
	always_ff @(posedge clk) begin
		if (cmd.adv2) begin
			pix_s2     <= 20'(yv_s1 * cfg.idim) + 20'(xv_s1);
			bufsize_s2 <= 20'(chk_s1 * cfg.k) * 20'(PIXELS_PER_BUFFER);
		end
	end

	assign offset = 31'(pix_s2 * cfg.ch) + 31'(chan_q);
	assign bfull  = plast_s1 && ((21'(buf_pos_q) + 21'd1) >= 21'(bufsize_s2));

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			input_offset <= zf_s1 ? 30'd0 : offset[29:0];
			zero_fill    <= zf_s1;
			buffer_index <= buf_pos_q[18:0];
			patch_last   <= plast_s1;
			buffer_full  <= bfull;
			scan_done    <= sdone_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_row_q  <= '0;
			out_col_q  <= '0;
			tap_row_q  <= '0;
			tap_col_q  <= '0;
			chan_q     <= '0;
			buf_pos_q  <= '0;
			finished_q <= 1'b1;
		end else if (cmd.accept && restart) begin
			if (nonempty) begin
				out_row_q  <= cfg.row_start;
				out_col_q  <= '0;
				tap_row_q  <= '0;
				tap_col_q  <= '0;
				chan_q     <= '0;
				buf_pos_q  <= '0;
				finished_q <= 1'b0;
			end else begin
				finished_q <= 1'b1;
			end
		end else if (cmd.commit) begin
			buf_pos_q <= bfull ? 20'd0 : buf_pos_q + 20'd1;
			if (!chan_end) begin
				chan_q <= chan_q + 10'd1;
			end else begin
				chan_q <= '0;
				if (!col_end) begin
					tap_col_q <= tap_col_q + 4'd1;
				end else begin
					tap_col_q <= '0;
					if (!row_end) begin
						tap_row_q <= tap_row_q + 4'd1;
					end else begin
						tap_row_q <= '0;
						if (!pix_end) begin
							out_col_q <= out_col_q + 10'd1;
						end else begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 10'd1;
						end
					end
				end
			end
			if (sdone_s1) begin
				finished_q <= 1'b1;
			end
		end
	end

endmodule

/* rtl/core/im2col_padded_address_generator_top.sv */
// Top level of the im2col gather address generator with zero padding.
// Depends on im2col_pkg, im2col_cfg, im2col_ctrl and im2col_dp.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  restart
//   output   out_valid/ out_stall input_offset zero_fill buffer_index
//                                 patch_last buffer_full scan_done
//   config   cfg_we               cfg_index cfg_data
//
// An element passes in turn through accept, tap position, pixel index, offset multiply
// and commit; the result register loads at commit, which a stalled output can hold
// off. The chained multiplies of the offset set these steps.
// An input beat that yields no element (idle, empty scan) leaves the generator idle.
// Reset leaves the scan finished, waiting for a restart.
// The next input beat is taken while a result still waits; a stalled output
// holds the last stage until the result register is free.
module im2col_padded_address_generator_top import im2col_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [29:0]        input_offset,
	output logic               zero_fill,
	output logic [18:0]        buffer_index,
	output logic               patch_last,
	output logic               buffer_full,
	output logic               scan_done
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	im2col_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	im2col_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	im2col_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.restart      (restart),
		.stat         (stat),
		.input_offset (input_offset),
		.zero_fill    (zero_fill),
		.buffer_index (buffer_index),
		.patch_last   (patch_last),
		.buffer_full  (buffer_full),
		.scan_done    (scan_done)
	);

endmodule

/* rtl/core/im2col_chk.sv */
// Port-level checks for the im2col generator, bound to the top level.
// Depends on im2col_pkg and im2col_padded_address_generator_top.
module im2col_chk import im2col_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [29:0] input_offset,
	input logic        zero_fill,
	input logic [18:0] buffer_index,
	input logic        patch_last,
	input logic        buffer_full,
	input logic        scan_done
);

	a_zero_fill_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_fill |-> input_offset == 30'd0)
		else $error("zero fill beat carries a nonzero offset");

	a_marks_on_patch_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (buffer_full || scan_done) |-> patch_last)
		else $error("buffer or scan end away from a patch end");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat appeared without a busy cycle");

	a_stalled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(buffer_index)
			&& $stable(input_offset))
		else $error("stalled result beat changed");

endmodule

bind im2col_padded_address_generator_top im2col_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.input_offset (input_offset),
	.zero_fill    (zero_fill),
	.buffer_index (buffer_index),
	.patch_last   (patch_last),
	.buffer_full  (buffer_full),
	.scan_done    (scan_done)
);
